[rtl/nofw_pkg.sv]
`default_nettype none
package nofw_pkg;

   localparam int SIZE_W      = 32;
   localparam int INDEX_W     = 12;
   localparam int SPC_W       = 33;   // spacing, sum of two sizes
   localparam int SUM_W       = 35;   // sums of up to three spacings
   localparam int MUL1_W      = 2 * SUM_W;
   localparam int PROD_W      = 106;  // widest numerator or denominator
   localparam int DIV_W       = 140;  // dividend after fraction shift
   localparam int QUOT_BITS   = 32;
   localparam int QUEUE_DEPTH = 4;
   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W  = 16;

   localparam logic [31:0] WEIGHT_MAX = 32'h7FFF_FFFF;
   localparam logic [31:0] WEIGHT_MIN = 32'h8000_0000;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_LAYER_OFFSET     = 8'd0,
      CSR_HIGH_ORDER_FIRST = 8'd1,
      CSR_HIGH_ORDER_LAST  = 8'd2,
      CSR_FACE_MODE        = 8'd3
   } csr_index_type;

   typedef struct packed {
      logic [INDEX_W-1:0] layer_index;
      logic [SIZE_W-1:0]  size_back2;
      logic [SIZE_W-1:0]  size_back1;
      logic [SIZE_W-1:0]  size_here;
      logic [SIZE_W-1:0]  size_ahead;
   } req_type;

   typedef struct packed {
      logic signed [31:0] weight_far_prev;
      logic signed [31:0] weight_near_prev;
      logic signed [31:0] weight_near_next;
      logic signed [31:0] weight_far_next;
      logic               divide_fault;
   } rsp_type;

   typedef struct packed {
      logic [15:0] layer_offset;
      logic [15:0] high_order_first;
      logic [15:0] high_order_last;
      logic        face_mode;
   } cfg_type;

   typedef struct packed {
      logic             fourth;
      logic [SPC_W-1:0] am;
      logic [SPC_W-1:0] dx;
      logic [SPC_W-1:0] av;
   } work_type;

endpackage
`default_nettype wire

[rtl/nofw_queue.sv]
`default_nettype none
module nofw_queue
   import nofw_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     push,
   input  wire work_type push_data,
   output logic          full,
   input  wire logic     pop,
   output logic          empty,
   output work_type      head
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   work_type           mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign full  = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign head  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

`ifndef NO_ASSERTIONS
   a_no_overfill: assert property (@(posedge clock) disable iff (reset)
      push |-> !full) else $error("queue written while full");
   a_no_underrun: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty) else $error("queue read while empty");
   a_count_up: assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> count_ff == $past(count_ff) + 1'b1)
      else $error("queue count lost a write");
`endif

endmodule
`default_nettype wire

[rtl/nofw_front.sv]
`default_nettype none
module nofw_front
   import nofw_pkg::*;
#(
   parameter int MAX_LAYERS = 4096
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire cfg_type cfg,
   input  wire logic    push,
   input  wire req_type req_data,
   output logic         full,
   input  wire logic    take,
   output logic         work_empty,
   output work_type     work
);

   logic [16:0] glob;
   logic        in_table;
   logic        accept;
   work_type    item;
   logic        q_full;

   // range test on the global layer, no wrap
   always_comb begin
      glob     = 17'(req_data.layer_index) + 17'(cfg.layer_offset);
      in_table = 32'(req_data.layer_index) < 32'(MAX_LAYERS);
      item.fourth = in_table && (glob >= 17'(cfg.high_order_first))
                    && (glob <= 17'(cfg.high_order_last));
      if (cfg.face_mode) begin
         item.am = SPC_W'(req_data.size_back2);
         item.dx = SPC_W'(req_data.size_back1);
         item.av = SPC_W'(req_data.size_here);
      end else begin
         // sums are twice the means, weights are scale free
         item.am = SPC_W'(req_data.size_back2) + SPC_W'(req_data.size_back1);
         item.dx = SPC_W'(req_data.size_back1) + SPC_W'(req_data.size_here);
         item.av = SPC_W'(req_data.size_here) + SPC_W'(req_data.size_ahead);
      end
   end

   assign accept = push && !q_full;
   assign full   = q_full;

   nofw_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_data (item),
      .full      (q_full),
      .pop       (take),
      .empty     (work_empty),
      .head      (work)
   );

endmodule
`default_nettype wire

[rtl/nofw_div.sv]
`default_nettype none
module nofw_div
   import nofw_pkg::*;
#(
   parameter int FRAC_BITS = 24
) (
   input  wire logic              clock,
   input  wire logic              enable,
   input  wire logic [PROD_W-1:0] num,
   input  wire logic [PROD_W-1:0] den,
   input  wire logic              neg,
   output logic [31:0]            weight
);

   logic [DIV_W-1:0]     n0, d0;
   logic                 sat0;

   logic [DIV_W-1:0]     rem_ff [QUOT_BITS];
   logic [DIV_W-1:0]     dvs_ff [QUOT_BITS];
   logic [QUOT_BITS-1:0] quo_ff [QUOT_BITS+1];
   logic [QUOT_BITS:0]   sat_ff, dzero_ff, nzero_ff, neg_ff;
   logic [31:0]          weight_ff, weight_in;
   logic [QUOT_BITS-1:0] q;

   // rounding: (num * 2^(F+1) + den) / (2 den)
   always_comb begin
      n0   = (DIV_W'(num) << (FRAC_BITS + 1)) + DIV_W'(den);
      d0   = DIV_W'(den) << 1;
      sat0 = n0 >= (d0 << QUOT_BITS);
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rem_ff[0]   <= n0;
         dvs_ff[0]   <= d0;
         quo_ff[0]   <= '0;
         sat_ff[0]   <= sat0;
         dzero_ff[0] <= (den == '0);
         nzero_ff[0] <= (num == '0);
         neg_ff[0]   <= neg;
      end
   end

   // one quotient bit per stage, msb first
   for (genvar k = 0; k < QUOT_BITS; k++) begin : g_step
      logic [DIV_W-1:0] trial;
      logic             ge;
      assign trial = dvs_ff[k] << (QUOT_BITS - 1 - k);
      assign ge    = rem_ff[k] >= trial;
      always_ff @(posedge clock) begin
         if (enable) begin
            quo_ff[k+1]   <= quo_ff[k]
                             | (ge ? (QUOT_BITS'(1) << (QUOT_BITS - 1 - k)) : '0);
            sat_ff[k+1]   <= sat_ff[k];
            dzero_ff[k+1] <= dzero_ff[k];
            nzero_ff[k+1] <= nzero_ff[k];
            neg_ff[k+1]   <= neg_ff[k];
         end
      end
      // the last stage needs no remainder after it
      if (k < QUOT_BITS - 1) begin : g_carry
         always_ff @(posedge clock) begin
            if (enable) begin
               rem_ff[k+1] <= ge ? rem_ff[k] - trial : rem_ff[k];
               dvs_ff[k+1] <= dvs_ff[k];
            end
         end
      end
   end

   always_comb begin
      q = quo_ff[QUOT_BITS];
      if (dzero_ff[QUOT_BITS]) begin
         if (nzero_ff[QUOT_BITS]) begin
            weight_in = '0;
         end else begin
            weight_in = neg_ff[QUOT_BITS] ? WEIGHT_MIN : WEIGHT_MAX;
         end
      end else if (sat_ff[QUOT_BITS]) begin
         weight_in = neg_ff[QUOT_BITS] ? WEIGHT_MIN : WEIGHT_MAX;
      end else if (neg_ff[QUOT_BITS]) begin
         weight_in = (q > WEIGHT_MIN) ? WEIGHT_MIN : 32'(0) - 32'(q);
      end else begin
         weight_in = q[QUOT_BITS-1] ? WEIGHT_MAX : 32'(q);
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         weight_ff <= weight_in;
      end
   end

   assign weight = weight_ff;

endmodule
`default_nettype wire

[rtl/nofw_back.sv]
`default_nettype none
module nofw_back
   import nofw_pkg::*;
#(
   parameter int FRAC_BITS = 24
) (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     work_empty,
   input  wire work_type work,
   output logic          work_take,
   output logic          empty,
   input  wire logic     pop,
   output rsp_type       rsp_data
);

   // three product stages, setup, one stage per quotient bit, final rounding
   localparam int DIV_LAT = QUOT_BITS + 2;
   localparam int LINE    = 3 + DIV_LAT;

   logic               enable;
   logic [LINE-1:0]    valid_ff, fourth_ff, fault_ff;
   logic               out_valid_ff;
   rsp_type            out_ff, out_in;

   logic [SUM_W-1:0]   s, pa, pv, xa, xv;

   logic [MUL1_W-1:0]  p_dd_ff, p_sxa_ff, p_avxa_ff, p_amxv_ff, p_papv_ff, p_sav_ff;
   logic [SUM_W-1:0]   am1_ff, pa1_ff, pv1_ff, xv1_ff;

   // split products, low and high halves of the wide operand
   logic [MUL1_W-1:0]  n1_lo_ff, n1_hi_ff, d1_lo_ff, d1_hi_ff;
   logic [MUL1_W-1:0]  n4_lo_ff, n4_hi_ff, d4_lo_ff, d4_hi_ff;
   logic [MUL1_W-1:0]  n2_m_ff, d2_m_ff, d3_m_ff;

   logic [PROD_W-1:0]  n1_ff, d1_ff, n2_ff, d2_ff, d3_ff, n4_ff, d4_ff;
   logic [31:0]        w_fp, w_np, w_nn, w_fn;

   assign enable    = !out_valid_ff || pop;
   assign work_take = enable && !work_empty;

   always_comb begin
      s  = SUM_W'(work.am) + SUM_W'(work.dx) + SUM_W'(work.av);
      pa = SUM_W'(work.dx) + (SUM_W'(work.am) << 1);
      pv = SUM_W'(work.dx) + (SUM_W'(work.av) << 1);
      xa = SUM_W'(work.dx) + SUM_W'(work.am);
      xv = SUM_W'(work.dx) + SUM_W'(work.av);
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         p_dd_ff   <= MUL1_W'(work.dx) * MUL1_W'(work.dx);
         p_sxa_ff  <= MUL1_W'(s) * MUL1_W'(xa);
         p_avxa_ff <= MUL1_W'(work.av) * MUL1_W'(xa);
         p_amxv_ff <= MUL1_W'(work.am) * MUL1_W'(xv);
         p_papv_ff <= MUL1_W'(pa) * MUL1_W'(pv);
         p_sav_ff  <= MUL1_W'(s) * MUL1_W'(work.av);
         am1_ff    <= SUM_W'(work.am);
         pa1_ff    <= pa;
         pv1_ff    <= pv;
         xv1_ff    <= xv;

         n1_lo_ff <= MUL1_W'(p_dd_ff[SUM_W-1:0]) * MUL1_W'(pv1_ff);
         n1_hi_ff <= MUL1_W'(p_dd_ff[MUL1_W-1:SUM_W]) * MUL1_W'(pv1_ff);
         d1_lo_ff <= MUL1_W'(p_sxa_ff[SUM_W-1:0]) * MUL1_W'(am1_ff);
         d1_hi_ff <= MUL1_W'(p_sxa_ff[MUL1_W-1:SUM_W]) * MUL1_W'(am1_ff);
         n4_lo_ff <= MUL1_W'(p_dd_ff[SUM_W-1:0]) * MUL1_W'(pa1_ff);
         n4_hi_ff <= MUL1_W'(p_dd_ff[MUL1_W-1:SUM_W]) * MUL1_W'(pa1_ff);
         d4_lo_ff <= MUL1_W'(p_sav_ff[SUM_W-1:0]) * MUL1_W'(xv1_ff);
         d4_hi_ff <= MUL1_W'(p_sav_ff[MUL1_W-1:SUM_W]) * MUL1_W'(xv1_ff);
         n2_m_ff  <= p_papv_ff;
         d2_m_ff  <= p_amxv_ff;
         d3_m_ff  <= p_avxa_ff;

         n1_ff <= PROD_W'(n1_lo_ff) + (PROD_W'(n1_hi_ff) << SUM_W);
         d1_ff <= (PROD_W'(d1_lo_ff) + (PROD_W'(d1_hi_ff) << SUM_W)) << 3;
         n2_ff <= PROD_W'(n2_m_ff);
         d2_ff <= PROD_W'(d2_m_ff) << 3;
         d3_ff <= PROD_W'(d3_m_ff) << 3;
         n4_ff <= PROD_W'(n4_lo_ff) + (PROD_W'(n4_hi_ff) << SUM_W);
         d4_ff <= (PROD_W'(d4_lo_ff) + (PROD_W'(d4_hi_ff) << SUM_W)) << 3;
      end
   end

   nofw_div #(.FRAC_BITS(FRAC_BITS)) u_div_fp (
      .clock(clock), .enable(enable), .num(n1_ff), .den(d1_ff), .neg(1'b1), .weight(w_fp));
   nofw_div #(.FRAC_BITS(FRAC_BITS)) u_div_np (
      .clock(clock), .enable(enable), .num(n2_ff), .den(d2_ff), .neg(1'b0), .weight(w_np));
   nofw_div #(.FRAC_BITS(FRAC_BITS)) u_div_nn (
      .clock(clock), .enable(enable), .num(n2_ff), .den(d3_ff), .neg(1'b0), .weight(w_nn));
   nofw_div #(.FRAC_BITS(FRAC_BITS)) u_div_fn (
      .clock(clock), .enable(enable), .num(n4_ff), .den(d4_ff), .neg(1'b1), .weight(w_fn));

   // some denominator vanishes exactly when am or av is zero
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (enable) begin
         valid_ff <= {valid_ff[LINE-2:0], work_take};
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         fourth_ff <= {fourth_ff[LINE-2:0], work.fourth};
         fault_ff  <= {fault_ff[LINE-2:0], (work.am == '0) || (work.av == '0)};
      end
   end

   always_comb begin
      if (fourth_ff[LINE-1]) begin
         out_in.weight_far_prev  = w_fp;
         out_in.weight_near_prev = w_np;
         out_in.weight_near_next = w_nn;
         out_in.weight_far_next  = w_fn;
         out_in.divide_fault     = fault_ff[LINE-1];
      end else begin
         out_in.weight_far_prev  = '0;
         out_in.weight_near_prev = 32'(1) << (FRAC_BITS - 1);
         out_in.weight_near_next = 32'(1) << (FRAC_BITS - 1);
         out_in.weight_far_next  = '0;
         out_in.divide_fault     = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (enable) begin
         out_valid_ff <= valid_ff[LINE-1];
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         out_ff <= out_in;
      end
   end

   assign empty    = !out_valid_ff;
   assign rsp_data = out_ff;

`ifndef NO_ASSERTIONS
   a_line_holds: assert property (@(posedge clock) disable iff (reset)
      !enable |=> $stable(valid_ff)) else $error("pipeline moved while stalled");
   a_line_delivers: assert property (@(posedge clock) disable iff (reset)
      enable && valid_ff[LINE-1] |=> out_valid_ff)
      else $error("finished item dropped at output");
   a_take_only_when_free: assert property (@(posedge clock) disable iff (reset)
      work_take |-> (!out_valid_ff || pop)) else $error("item taken during stall");
`endif

endmodule
`default_nettype wire

[rtl/nonuniform_fourth_order_weights.sv]
// path from the push transfer to the result showing on the result ports: the queue write,
// then three product stages, divider setup, 32 quotient stages, rounding, output
// throughput: one item per cycle while the output is not stalled, set by the fully pipelined quotient stages
// a stalled output freezes the back pipeline; the 4-entry queue takes items until full
// reset (synchronous, active high) empties queue and pipeline, clears config registers to 0
`default_nettype none
module nonuniform_fourth_order_weights
   import nofw_pkg::*;
#(
   parameter int MAX_LAYERS = 4096,
   parameter int FRAC_BITS  = 24
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   // input queue side
   input  wire logic                   push,
   output logic                        full,
   input  wire req_type                req_data,
   // result queue side
   output logic                        empty,
   input  wire logic                   pop,
   output rsp_type                     rsp_data,
   // register writes
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data
);

   cfg_type  cfg_ff, cfg_in;
   logic     work_empty;
   logic     work_take;
   work_type work;

   // register writes always complete in one transfer
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_LAYER_OFFSET:     cfg_in.layer_offset     = csr_data;
            CSR_HIGH_ORDER_FIRST: cfg_in.high_order_first = csr_data;
            CSR_HIGH_ORDER_LAST:  cfg_in.high_order_last  = csr_data;
            CSR_FACE_MODE:        cfg_in.face_mode        = csr_data[0];
            default:              cfg_in = cfg_ff;   // unmapped index is ignored
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front: range test and spacings, into the work queue
   nofw_front #(.MAX_LAYERS(MAX_LAYERS)) u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .push       (push),
      .req_data   (req_data),
      .full       (full),
      .take       (work_take),
      .work_empty (work_empty),
      .work       (work)
   );

   // back: products, four pipelined dividers, output register
   nofw_back #(.FRAC_BITS(FRAC_BITS)) u_back (
      .clock      (clock),
      .reset      (reset),
      .work_empty (work_empty),
      .work       (work),
      .work_take  (work_take),
      .empty      (empty),
      .pop        (pop),
      .rsp_data   (rsp_data)
   );

endmodule
`default_nettype wire
